// ===== rtl/core/can_receive_mailbox_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the CAN receive mailbox table
// Each check is compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef CAN_RECEIVE_MAILBOX_TABLE_MACROS_SVH
`define CAN_RECEIVE_MAILBOX_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define CRMT_ASSERT_SAME(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed in mailbox table");

// Next-cycle implication, disabled during reset
`define CRMT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed in mailbox table");

`else

`define CRMT_ASSERT_SAME(label, clk, rst, lhs, rhs)
`define CRMT_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

// ===== rtl/core/crmt_pkg.sv =====
// ----------------------------------------------------------------------------
// crmt_pkg
// Types, constants and helpers shared by the mailbox table and its cells.
// ----------------------------------------------------------------------------
package crmt_pkg;

   localparam int MAILBOXES_DEF = 16;
   localparam int STD_SLOTS_DEF = 8;

   localparam int FUNC_W  = 3;
   localparam int IDENT_W = 29;
   localparam int SLOT_W  = 4;
   localparam int LEN_W   = 4;
   localparam int DATA_W  = 64;
   localparam int BYTES   = DATA_W / 8;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BYTES);

   typedef enum logic [FUNC_W-1:0] {
      OP_ALLOC   = 3'd0,
      OP_SETWAIT = 3'd1,
      OP_INSERT  = 3'd2,
      OP_GETMSG  = 3'd3,
      OP_GETREQ  = 3'd4
   } op_type;

   // Operation broadcast to every cell for the whole search
   typedef struct packed {
      op_type               func;
      logic [IDENT_W-1:0]   ident;
      logic                 extended;
      logic [SLOT_W-1:0]    hint;
      logic                 hint_pass;
      logic [LEN_W-1:0]     length;
      logic [DATA_W-1:0]    data;
   } query_type;

   // Wavefront handed from cell to cell
   typedef struct packed {
      logic                 active;
      logic                 done;
      logic [SLOT_W-1:0]    slot;
      logic [IDENT_W-1:0]   ident;
      logic [LEN_W-1:0]     length;
      logic [DATA_W-1:0]    data;
   } carry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LAUNCH,
      S_WAIT,
      S_RESP
   } state_type;

   // Zero the payload bytes at and beyond the length
   function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] data,
                                                   input logic [LEN_W-1:0]  len);
      logic [DATA_W-1:0] res;
      res = data;
      for (int b = 0; b < BYTES; b++) begin
         if (LEN_W'(b) >= len) begin
            res[b*8 +: 8] = 8'h00;
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/crmt_cell.sv =====
// ----------------------------------------------------------------------------
// crmt_cell
// One mailbox of the table: holds its identifier, new-data flag, length and
// payload, and acts on the search wavefront as it passes through.
// ----------------------------------------------------------------------------
module crmt_cell
   import crmt_pkg::*;
#(
   parameter int INDEX     = 0,
   parameter int STD_LIMIT = STD_SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  query_type query,
   input  carry_type carry_in,
   output carry_type carry_out
);

   localparam bit IS_WAIT = (INDEX == 0);
   localparam bit IN_EXT  = (INDEX >= STD_LIMIT);

   logic [IDENT_W-1:0] ident_ff, ident_in;
   logic               fresh_ff, fresh_in;
   logic [LEN_W-1:0]   length_ff;
   logic [DATA_W-1:0]  data_ff;
   carry_type          carry_ff, carry_in_next;

   logic in_region;
   logic id_match;
   logic hint_match;
   logic hit;
   logic take;
   logic is_read;

   // Decide whether this mailbox answers the operation
   always_comb begin
      in_region  = query.extended ? IN_EXT : !IN_EXT;
      id_match   = (ident_ff == query.ident);
      hint_match = (int'(query.hint) == INDEX);
      hit        = 1'b0;
      is_read    = 1'b0;
      unique case (query.func)
         OP_ALLOC:   hit = in_region && (query.extended || !IS_WAIT) && (ident_ff == '0);
         OP_SETWAIT: hit = IS_WAIT;
         OP_INSERT:  hit = id_match && (!query.hint_pass || hint_match);
         OP_GETMSG: begin
            hit     = in_region && fresh_ff && id_match;
            is_read = 1'b1;
         end
         OP_GETREQ: begin
            hit     = IS_WAIT && fresh_ff;
            is_read = 1'b1;
         end
         default:    hit = 1'b0;
      endcase
      take = carry_in.active && !carry_in.done && hit;
   end

   // Next state of the mailbox
   always_comb begin
      ident_in = ident_ff;
      fresh_in = fresh_ff;
      if (take) begin
         case (query.func) inside
            OP_ALLOC, OP_SETWAIT: ident_in = query.ident;
            OP_INSERT:            fresh_in = 1'b1;
            OP_GETMSG:            fresh_in = 1'b0;
            OP_GETREQ: begin
               fresh_in = 1'b0;
               ident_in = '0;
            end
            default: ;
         endcase
      end
   end

   // Mark the wavefront and attach read data when this cell answers
   always_comb begin
      carry_in_next = carry_in;
      if (take) begin
         carry_in_next.done = 1'b1;
         carry_in_next.slot = SLOT_W'(INDEX);
         if (is_read) begin
            carry_in_next.ident  = ident_ff;
            carry_in_next.length = length_ff;
            carry_in_next.data   = data_ff;
         end
      end
   end

   // Hold identifier, flag and wavefront stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff <= '0;
         fresh_ff <= 1'b0;
         carry_ff <= '0;
      end else begin
         ident_ff <= ident_in;
         fresh_ff <= fresh_in;
         carry_ff <= carry_in_next;
      end
   end

   // Store a received frame
   always_ff @(posedge clock) begin
      if (take && (query.func == OP_INSERT)) begin
         length_ff <= query.length;
         data_ff   <= query.data;
      end
   end

   assign carry_out = carry_ff;

endmodule

// ===== rtl/core/can_receive_mailbox_table.sv =====
// A response follows its request transaction once the wavefront has walked the chain;
// an insert whose hint misses makes a second pass over the chain.
// Only one operation is in flight at a time: a new request is taken only after the
// response has been accepted, and the wavefront walks one cell a cycle.
// Reset (synchronous, active high) frees every mailbox and clears all flags.
// ----------------------------------------------------------------------------
// can_receive_mailbox_table
// CAN receive mailbox table built as a chain of mailbox cells. A wavefront
// carrying the operation's result walks the chain; the first cell that
// matches takes the operation and marks the wavefront done.
// ----------------------------------------------------------------------------
`include "can_receive_mailbox_table_macros.svh"

module can_receive_mailbox_table
   import crmt_pkg::*;
#(
   parameter int MAILBOXES = MAILBOXES_DEF,
   parameter int STD_SLOTS = STD_SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // ident[28:0], hint_slot[32:29], length[36:33], payload[100:37], zero pad
   input  logic [103:0] req_tdata,
   // func[2:0], extended[3]
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot[3:0], ident_out[32:4], length_out[36:33], payload_out[100:37], zero pad
   output logic [103:0] rsp_tdata,
   // status[0]
   output logic [0:0]   rsp_tuser
);

   localparam int STD_LIMIT = (STD_SLOTS > MAILBOXES) ? MAILBOXES : STD_SLOTS;

   state_type state_ff, state_in;
   query_type query_ff, query_in;
   carry_type result_ff, result_in;
   carry_type chain [MAILBOXES+1];
   logic [MAILBOXES-1:0] wave_active;

   logic req_fire;
   logic rsp_fire;
   logic pass_end;
   logic relaunch;
   logic [LEN_W-1:0] len_sat;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign pass_end = chain[MAILBOXES].active;
   assign relaunch = pass_end && query_ff.hint_pass && !chain[MAILBOXES].done;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_fire) state_in = S_LAUNCH;
         S_LAUNCH: state_in = S_WAIT;
         S_WAIT: begin
            if (relaunch) begin
               state_in = S_LAUNCH;
            end else if (pass_end) begin
               state_in = S_RESP;
            end
         end
         S_RESP:   if (rsp_fire) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Handshake outputs and wavefront launch
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      chain[0]   = '0;
      unique case (state_ff)
         S_IDLE:   req_tready = !reset;
         S_LAUNCH: chain[0].active = 1'b1;
         S_WAIT:   ;
         S_RESP:   rsp_tvalid = 1'b1;
         default:  ;
      endcase
   end

   // Capture the request; saturate length and trim the payload
   always_comb begin
      query_in = query_ff;
      len_sat  = (req_tdata[36:33] > LEN_MAX) ? LEN_MAX : req_tdata[36:33];
      if (req_fire) begin
         query_in.func      = op_type'(req_tuser[2:0]);
         query_in.ident     = req_tdata[28:0];
         query_in.extended  = req_tuser[3];
         query_in.hint      = req_tdata[32:29];
         query_in.hint_pass = (op_type'(req_tuser[2:0]) == OP_INSERT);
         query_in.length    = len_sat;
         query_in.data      = keep_bytes(req_tdata[100:37], len_sat);
      end else if (relaunch) begin
         query_in.hint_pass = 1'b0;
      end
   end

   // Latch the wavefront at the end of the chain as the response
   always_comb begin
      result_in = result_ff;
      if ((state_ff == S_WAIT) && pass_end && !relaunch) begin
         result_in = chain[MAILBOXES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff  <= query_in;
      result_ff <= result_in;
   end

   // Chain of mailbox cells
   for (genvar i = 0; i < MAILBOXES; i++) begin : g_cell
      crmt_cell #(
         .INDEX     (i),
         .STD_LIMIT (STD_LIMIT)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .query     (query_ff),
         .carry_in  (chain[i]),
         .carry_out (chain[i+1])
      );
      assign wave_active[i] = chain[i+1].active;
   end

   // Response fields
   assign rsp_tuser[0]       = !result_ff.done;
   assign rsp_tdata[3:0]     = result_ff.slot;
   assign rsp_tdata[32:4]    = result_ff.ident;
   assign rsp_tdata[36:33]   = result_ff.length;
   assign rsp_tdata[100:37]  = result_ff.data;
   assign rsp_tdata[103:101] = '0;

   // Checks
   `CRMT_ASSERT_SAME(a_single_wave, clock, reset, 1'b1, $onehot0(wave_active))
   `CRMT_ASSERT_SAME(a_end_in_wait, clock, reset, pass_end, state_ff == S_WAIT)
   `CRMT_ASSERT_NEXT(a_launch_after_req, clock, reset, req_fire, chain[0].active)
   `CRMT_ASSERT_SAME(a_getreq_slot0, clock, reset,
                     rsp_tvalid && !rsp_tuser[0] && (query_ff.func == OP_GETREQ),
                     rsp_tdata[3:0] == '0)

endmodule

// ===== tb/sv/tb_can_receive_mailbox_table.sv =====
// ----------------------------------------------------------------------------
// tb_can_receive_mailbox_table
// Self-checking bench for the CAN receive mailbox table. It runs a short
// directed walk through allocation, insertion, reads, the wait slot and
// table-full cases, then random operation streams with identifiers mostly
// drawn from the mailboxes in use. Every response transaction is checked
// field by field against the directed table's expected response or an in-bench model.
// ----------------------------------------------------------------------------
module tb_can_receive_mailbox_table
   import crmt_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BOX         = MAILBOXES_DEF;
   localparam int STD_BOX         = STD_SLOTS_DEF;
   localparam int ITEMS_PER_PHASE = 500;
   localparam int GAP_MAX         = 2 * NUM_BOX + 8;
   localparam int QUIET_LIMIT     = 2000;
   localparam int REPORT_MAX      = 10;
   localparam int POOL_SIZE       = 6;

   // Function codes the block does not implement
   localparam logic [FUNC_W-1:0]  FUNC_BAD_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0]  FUNC_BAD_LAST  = 3'd7;
   localparam logic [IDENT_W-1:0] IDENT_ONES     = '1;
   localparam logic [DATA_W-1:0]  DATA_ONES      = '1;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [IDENT_W-1:0] ident;
      logic               ext;
      logic [SLOT_W-1:0]  hint;
      logic [LEN_W-1:0]   len;
      logic [DATA_W-1:0]  data;
   } mb_req_t;

   typedef struct packed {
      logic               status;
      logic [SLOT_W-1:0]  slot;
      logic [IDENT_W-1:0] ident;
      logic [LEN_W-1:0]   len;
      logic [DATA_W-1:0]  data;
   } mb_rsp_t;

   typedef struct packed {
      mb_req_t req;
      logic    typed;
      mb_rsp_t rsp;
   } dir_row_t;

   localparam mb_rsp_t MISS       = '{1'b1, 4'd0, 29'h0, 4'd0, 64'h0};
   localparam mb_rsp_t DONE_SLOT0 = '{1'b0, 4'd0, 29'h0, 4'd0, 64'h0};

   // Directed walk; rows with typed = 0 are checked against the model
   localparam dir_row_t DIR_ROWS [25] = '{
      '{'{OP_GETREQ, 29'h0, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1, MISS},
      '{'{OP_GETMSG, 29'h0, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1, MISS},
      '{'{FUNC_BAD_LAST, IDENT_ONES, 1'b1, 4'hF, 4'hF, DATA_ONES}, 1'b1, MISS},
      '{'{OP_ALLOC, IDENT_ONES, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd1, 29'h0, 4'd0, 64'h0}},
      '{'{OP_ALLOC, 29'h155, 1'b1, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd8, 29'h0, 4'd0, 64'h0}},
      // length above eight saturates
      '{'{OP_INSERT, IDENT_ONES, 1'b0, 4'd1, 4'hF, DATA_ONES}, 1'b1,
        '{1'b0, 4'd1, 29'h0, 4'd0, 64'h0}},
      '{'{OP_GETMSG, IDENT_ONES, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd1, IDENT_ONES, 4'd8, DATA_ONES}},
      // hint misses, search finds the slot; bytes beyond length cleared
      '{'{OP_INSERT, 29'h155, 1'b1, 4'hF, 4'd3, 64'h1122_3344_5566_7788}, 1'b1,
        '{1'b0, 4'd8, 29'h0, 4'd0, 64'h0}},
      '{'{OP_GETMSG, 29'h155, 1'b1, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd8, 29'h155, 4'd3, 64'h66_7788}},
      '{'{OP_SETWAIT, 29'h42, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1, DONE_SLOT0},
      '{'{OP_INSERT, 29'h42, 1'b0, 4'd0, 4'd0, 64'hFFFF}, 1'b1, DONE_SLOT0},
      '{'{OP_GETREQ, 29'h0, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd0, 29'h42, 4'd0, 64'h0}},
      '{'{OP_GETREQ, 29'h0, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1, MISS},
      // identifier zero matches a free slot on insert
      '{'{OP_INSERT, 29'h0, 1'b0, 4'd2, 4'd5, 64'hA5A5_5A5A_C3C3_3C3C}, 1'b1,
        '{1'b0, 4'd2, 29'h0, 4'd0, 64'h0}},
      // allocating identifier zero succeeds but leaves the slot free
      '{'{OP_ALLOC, 29'h0, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd2, 29'h0, 4'd0, 64'h0}},
      '{'{OP_GETMSG, 29'h0, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b0, MISS},
      '{'{OP_GETMSG, 29'h0, 1'b1, 4'd0, 4'd0, 64'h0}, 1'b1, MISS},
      // fill the standard region, then overflow it
      '{'{OP_ALLOC, 29'h101, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd2, 29'h0, 4'd0, 64'h0}},
      '{'{OP_ALLOC, 29'h102, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd3, 29'h0, 4'd0, 64'h0}},
      '{'{OP_ALLOC, 29'h103, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd4, 29'h0, 4'd0, 64'h0}},
      '{'{OP_ALLOC, 29'h104, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd5, 29'h0, 4'd0, 64'h0}},
      '{'{OP_ALLOC, 29'h105, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd6, 29'h0, 4'd0, 64'h0}},
      '{'{OP_ALLOC, 29'h106, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1,
        '{1'b0, 4'd7, 29'h0, 4'd0, 64'h0}},
      '{'{OP_ALLOC, 29'h107, 1'b0, 4'd0, 4'd0, 64'h0}, 1'b1, MISS},
      // no mailbox holds this identifier
      '{'{OP_INSERT, 29'h1234, 1'b1, 4'd4, 4'd8, DATA_ONES}, 1'b1, MISS}
   };

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata   = '0;
   logic [3:0]   req_tuser   = '0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [103:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   int send_idle_pct = 30;
   int recv_idle_pct = 48;
   int mismatch_cnt  = 0;
   int quiet_cycles  = 0;

   // Model of the mailbox contents
   logic [IDENT_W-1:0] box_ident [NUM_BOX] = '{default: '0};
   logic               box_fresh [NUM_BOX] = '{default: 1'b0};
   logic [LEN_W-1:0]   box_len   [NUM_BOX] = '{default: '0};
   logic [DATA_W-1:0]  box_data  [NUM_BOX] = '{default: '0};

   logic [IDENT_W-1:0] id_pool [POOL_SIZE];
   mb_rsp_t            awaited_rsp_q [$];

   can_receive_mailbox_table #(
      .MAILBOXES (NUM_BOX),
      .STD_SLOTS (STD_BOX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one operation to the mailbox model and return its response
   function automatic mb_rsp_t mailbox_step(input mb_req_t it);
      mb_rsp_t          res;
      logic [LEN_W-1:0] len;
      int               lo, hi, tgt;
      bit               hit;
      res = MISS;
      len = (it.len > LEN_MAX) ? LEN_MAX : it.len;
      lo  = it.ext ? STD_BOX : 0;
      hi  = it.ext ? NUM_BOX : STD_BOX;
      hit = 1'b0;
      tgt = 0;
      case (it.func)
         OP_ALLOC: begin
            // standard region skips the wait slot
            for (int i = (it.ext ? lo : 1); i < hi && !hit; i++) begin
               if (box_ident[i] == '0) begin
                  box_ident[i] = it.ident;
                  res.status   = 1'b0;
                  res.slot     = SLOT_W'(i);
                  hit          = 1'b1;
               end
            end
         end
         OP_SETWAIT: begin
            box_ident[0] = it.ident;
            res.status   = 1'b0;
         end
         OP_INSERT: begin
            // hinted slot first, then the lowest matching slot
            if (int'(it.hint) < NUM_BOX && box_ident[it.hint] == it.ident) begin
               tgt = int'(it.hint);
               hit = 1'b1;
            end
            for (int i = 0; i < NUM_BOX && !hit; i++) begin
               if (box_ident[i] == it.ident) begin
                  tgt = i;
                  hit = 1'b1;
               end
            end
            if (hit) begin
               box_len[tgt]   = len;
               box_data[tgt]  = (len >= LEN_MAX) ? it.data :
                                it.data & ((64'd1 << (8 * int'(len))) - 64'd1);
               box_fresh[tgt] = 1'b1;
               res.status     = 1'b0;
               res.slot       = SLOT_W'(tgt);
            end
         end
         OP_GETMSG: begin
            for (int i = lo; i < hi && !hit; i++) begin
               if (box_fresh[i] && box_ident[i] == it.ident) begin
                  res          = '{1'b0, SLOT_W'(i), box_ident[i], box_len[i], box_data[i]};
                  box_fresh[i] = 1'b0;
                  hit          = 1'b1;
               end
            end
         end
         OP_GETREQ: begin
            if (box_fresh[0]) begin
               res          = '{1'b0, SLOT_W'(0), box_ident[0], box_len[0], box_data[0]};
               box_fresh[0] = 1'b0;
               box_ident[0] = '0;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Random operation, identifiers mostly taken from the mailboxes in use
   function automatic mb_req_t random_item();
      mb_req_t it;
      int      pick, slot_sel;
      pick = $urandom_range(99);
      if (pick < 8)       it.func = OP_ALLOC;
      else if (pick < 16) it.func = OP_SETWAIT;
      else if (pick < 50) it.func = OP_INSERT;
      else if (pick < 82) it.func = OP_GETMSG;
      else if (pick < 94) it.func = OP_GETREQ;
      else it.func = FUNC_W'($urandom_range(FUNC_BAD_LAST, FUNC_BAD_FIRST));
      slot_sel = $urandom_range(NUM_BOX - 1);
      pick     = $urandom_range(99);
      if (pick < 55) begin
         it.ident = box_ident[slot_sel];
         it.ext   = (slot_sel >= STD_BOX) ^ ($urandom_range(99) < 15);
      end else if (pick < 80) begin
         it.ident = id_pool[$urandom_range(POOL_SIZE - 1)];
         it.ext   = 1'($urandom_range(1));
      end else begin
         it.ident = IDENT_W'($urandom);
         it.ext   = 1'($urandom_range(1));
      end
      it.hint = $urandom_range(1) ? SLOT_W'(slot_sel) : SLOT_W'($urandom_range(NUM_BOX - 1));
      it.len  = LEN_W'($urandom_range(15));
      it.data = {$urandom, $urandom};
      return it;
   endfunction

   // Present one request transaction, hold until accepted, then maybe idle
   task automatic send_item(input mb_req_t it, input logic typed, input mb_rsp_t typed_rsp);
      mb_rsp_t pred;
      req_tvalid <= 1'b1;
      req_tdata  <= 104'({it.data, it.len, it.hint, it.ident});
      req_tuser  <= {it.ext, it.func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = mailbox_step(it);
      awaited_rsp_q.push_back(typed ? typed_rsp : pred);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(GAP_MAX, 1)) @(posedge clock);
      end
   endtask

   // Hold off the sender until every response has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Random back-pressure on the response channel
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Check each response transaction against the oldest expectation
   always @(posedge clock) begin
      mb_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser[0], rsp_tdata[3:0], rsp_tdata[32:4], rsp_tdata[36:33],
                 rsp_tdata[100:37]};
         if (awaited_rsp_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
               $display("unexpected response: status %0d slot %0d ident %h len %0d data %h",
                        got.status, got.slot, got.ident, got.len, got.data);
         end else begin
            want = awaited_rsp_q.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.ident !== want.ident || got.len !== want.len ||
                got.data !== want.data) begin
               mismatch_cnt++;
               if (mismatch_cnt <= REPORT_MAX) begin
                  $display("mismatch: exp status %0d slot %0d ident %h len %0d data %h",
                           want.status, want.slot, want.ident, want.len, want.data);
                  $display("          got status %0d slot %0d ident %h len %0d data %h",
                           got.status, got.slot, got.ident, got.len, got.data);
               end
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: reset, directed walk, then three random phases
   initial begin
      foreach (id_pool[k])
         id_pool[k] = (k < POOL_SIZE / 2) ? IDENT_W'($urandom_range(11'h7FF, 1))
                                          : IDENT_W'($urandom);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIR_ROWS); r++)
         send_item(DIR_ROWS[r].req, DIR_ROWS[r].typed, DIR_ROWS[r].rsp);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 48 : 0;
         recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 30 : 0;
         repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, MISS);
         drain();
      end

      repeat (GAP_MAX) @(posedge clock);
      if (mismatch_cnt == 0 && awaited_rsp_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
